// ----- rtl/tdpi_pkg.sv -----
// ----------------------------------------------------------------------------
// tdpi_pkg: shared types and constants
// Operation and status codes, default table depth, command queue entry.
// ----------------------------------------------------------------------------
package tdpi_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [TimeW-1:0]  entry_time;
    logic [DelayW-1:0] entry_delay;
  } cmd_t;

endpackage

// ----- rtl/tdpi_if.sv -----
// ----------------------------------------------------------------------------
// tdpi_in_if / tdpi_out_if / tdpi_cfg_if: valid/ready channels
// One interface per channel kind, each with source and sink modports.
// ----------------------------------------------------------------------------
interface tdpi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] entry_time;
  logic [15:0] entry_delay;
  modport source (output valid, output op, output entry_time, output entry_delay,
                  input ready);
  modport sink (input valid, input op, input entry_time, input entry_delay,
                output ready);
endinterface

interface tdpi_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] delay_out;
  logic [15:0] max_delay;
  logic [1:0]  status;
  modport source (output valid, output delay_out, output max_delay, output status,
                  input ready);
  modport sink (input valid, input delay_out, input max_delay, input status,
                output ready);
endinterface

interface tdpi_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tdpi_ram.sv -----
// ----------------------------------------------------------------------------
// tdpi_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tdpi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/tdpi_front.sv -----
// ----------------------------------------------------------------------------
// tdpi_front: input stage and command queue
// Accept input beats into a two-entry queue drained by the engine.
// ----------------------------------------------------------------------------
module tdpi_front
  import tdpi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  tdpi_in_if.sink      in_ch,
  output logic         cmd_valid,
  output cmd_t         cmd,
  input  logic         cmd_take
);
  cmd_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (cmd_take) rd_r <= ~rd_r;
    end
    if (push) begin
      q_r[wr_r] <= '{op: in_ch.op, entry_time: in_ch.entry_time,
                     entry_delay: in_ch.entry_delay};
    end
  end

  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid) else $error("take from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_full_noready: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ch.ready) else $error("ready while full");
endmodule

// ----- rtl/tdpi_div.sv -----
// ----------------------------------------------------------------------------
// tdpi_div: restoring divider
// Unsigned 48 / 32 division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);
  logic [47:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;
  logic [32:0] sh;

  assign sh       = {rem_r[31:0], q_r[47]};
  assign trial    = sh - {1'b0, dvs_r};
  assign quotient = q_r;
  assign done     = busy_r && (cnt_r == 6'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd48;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 6'd1;
    end
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r && cnt_r != 6'd0) begin
      if (!trial[32]) begin
        rem_r <= trial;
        q_r   <= {q_r[46:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r   <= {q_r[46:0], 1'b0};
      end
    end
  end
endmodule

// ----- rtl/tdpi_engine.sv -----
// ----------------------------------------------------------------------------
// tdpi_engine: table engine
// Execute queued commands: search, interpolate, load, rescan, clear.
// ----------------------------------------------------------------------------
module tdpi_engine
  import tdpi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      loop_mode,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  tdpi_out_if.source out_ch
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LREAD = 9'b000000010,
    S_LWAIT = 9'b000000100,
    S_SRCH  = 9'b000001000,
    S_SWAIT = 9'b000010000,
    S_PREV  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_SCAN  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t           st_r;
  cmd_t             c_r;
  logic [CW-1:0]    cnt_r;
  logic [31:0]      tick_r;
  logic [15:0]      max_r;
  logic [CW-1:0]    idx_r;
  logic [31:0]      t1_r;
  logic [15:0]      d1_r;
  logic [15:0]      dly_r;
  logic [1:0]       sts_r;
  logic             dgo_r;
  logic             ovld_r;
  logic             out_busy;
  logic             dstart;
  logic [47:0]      dividend, quot;
  logic [31:0]      divisor;
  logic             ddone;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [31:0]      wtime, rtime;
  logic [15:0]      wdelay, rdelay;
  logic             tw_en;
  logic [16:0]      dd;
  logic [15:0]      ddm;
  logic [31:0]      el;
  logic [47:0]      prod;
  logic [15:0]      qs;

  tdpi_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_times (
    .clk, .we(tw_en), .waddr, .wdata(wtime), .raddr, .rdata(rtime));
  tdpi_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_delays (
    .clk, .we, .waddr, .wdata(wdelay), .raddr, .rdata(rdelay));

  tdpi_div u_div (.clk, .rst_n, .start(dstart), .dividend, .divisor,
                  .done(ddone), .quotient(quot));

  assign out_busy      = ovld_r && !out_ch.ready;
  assign cmd_take      = (st_r == S_IDLE) && cmd_valid && !out_busy;
  assign out_ch.valid  = ovld_r;

  // Difference terms for the interpolation, t0/d0 from RAM read data
  assign dd   = {1'b0, d1_r} - {1'b0, rdelay};
  assign ddm  = dd[16] ? 16'(-dd) : dd[15:0];
  assign el   = tick_r - rtime;
  assign prod = 48'(ddm) * 48'(el);
  assign dividend = prod;
  assign divisor  = t1_r - rtime;
  assign dstart   = dgo_r;
  assign qs = quot[15:0];

  always_comb begin
    raddr = idx_r[AW-1:0];
    if (st_r == S_IDLE || st_r == S_LREAD) begin
      raddr = AW'(cnt_r - CW'(1));
    end
  end

  // Write path: append or replace last delay
  always_comb begin
    we     = 1'b0;
    tw_en  = 1'b0;
    waddr  = AW'(cnt_r - CW'(1));
    wtime  = c_r.entry_time;
    wdelay = c_r.entry_delay;
    if (st_r == S_LWAIT) begin
      if (cnt_r != '0 && c_r.entry_time == rtime) begin
        we = 1'b1;
      end else if (cnt_r != '0 && c_r.entry_time < rtime) begin
        we = 1'b0;
      end else if (cnt_r != DepthC) begin
        we    = 1'b1;
        tw_en = 1'b1;
        waddr = cnt_r[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      tick_r <= '0;
      max_r  <= '0;
      ovld_r <= 1'b0;
      dgo_r  <= 1'b0;
    end else begin
      dgo_r <= (st_r == S_PREV);
      if (st_r == S_OUT && !out_busy) ovld_r <= 1'b1;
      else if (out_ch.ready) ovld_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_take) begin
            c_r   <= cmd;
            dly_r <= '0;
            sts_r <= ST_OK;
            case (cmd.op)
              OP_TICK: begin
                tick_r <= tick_r + 32'd1;
                idx_r  <= '0;
                if (cnt_r == '0) begin
                  sts_r <= ST_EMPTY;
                  st_r  <= S_OUT;
                end else begin
                  st_r <= S_SRCH;
                end
              end
              OP_LOAD:  st_r <= S_LREAD;
              OP_CLEAR: begin
                cnt_r  <= '0;
                tick_r <= '0;
                max_r  <= '0;
                st_r   <= S_OUT;
              end
              default: st_r <= S_OUT;
            endcase
          end
        end
        S_LREAD: st_r <= S_LWAIT;
        S_LWAIT: begin
          if (cnt_r != '0 && c_r.entry_time == rtime) begin
            idx_r <= '0;
            max_r <= '0;
            st_r  <= S_SCAN;
          end else if (cnt_r != '0 && c_r.entry_time < rtime) begin
            sts_r <= ST_ORDER;
            st_r  <= S_OUT;
          end else if (cnt_r == DepthC) begin
            sts_r <= ST_FULL;
            st_r  <= S_OUT;
          end else begin
            cnt_r <= cnt_r + CW'(1);
            if (c_r.entry_delay > max_r) max_r <= c_r.entry_delay;
            st_r <= S_OUT;
          end
        end
        S_SRCH: st_r <= S_SWAIT;
        S_SWAIT: begin
          if (c_r.op == OP_CLEAR) begin
            dly_r <= rdelay;
            st_r  <= S_OUT;
          end else if (rtime >= tick_r) begin
            t1_r <= rtime;
            d1_r <= rdelay;
            if (idx_r == '0) begin
              dly_r <= rdelay;
              st_r  <= S_OUT;
            end else begin
              idx_r <= idx_r - CW'(1);
              st_r  <= S_PREV;
            end
          end else if (idx_r == cnt_r - CW'(1)) begin
            if (!loop_mode) begin
              dly_r <= rdelay;
              st_r  <= S_OUT;
            end else begin
              tick_r <= '0;
              idx_r  <= '0;
              c_r.op <= OP_CLEAR;
              st_r   <= S_SRCH;
            end
          end else begin
            idx_r <= idx_r + CW'(1);
            st_r  <= S_SRCH;
          end
        end
        S_PREV: st_r <= S_DIV;
        S_DIV: begin
          if (ddone) begin
            dly_r <= dd[16] ? rdelay - qs : rdelay + qs;
            st_r  <= S_OUT;
          end
        end
        S_SCAN: begin
          if (idx_r != '0 && rdelay > max_r) max_r <= rdelay;
          if (idx_r == cnt_r) begin
            st_r <= S_OUT;
          end else begin
            idx_r <= idx_r + CW'(1);
            st_r  <= S_SCAN;
          end
        end
        S_OUT: begin
          if (!out_busy) begin
            out_ch.delay_out <= dly_r;
            out_ch.max_delay <= max_r;
            out_ch.status    <= sts_r;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> !out_busy) else $error("take while output stalled");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DepthC) else $error("point count past depth");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    dstart |=> st_r == S_DIV) else $error("divider start out of sequence");
endmodule

// ----- rtl/timed_delay_profile_interpolator.sv -----
// ----------------------------------------------------------------------------
// timed_delay_profile_interpolator: piecewise linear delay profile
// Point table with tick search and interpolated delay output.
// ----------------------------------------------------------------------------
// channel | dir | fields
// in      | in  | op[1:0], entry_time[31:0], entry_delay[15:0]
// out     | out | delay_out[15:0], max_delay[15:0], status[1:0]
// cfg     | in  | data (loop_mode)
// Tick: serial RAM search for the first point at or past the tick, plus a
// 48-step divider; an equal-time load replaces the delay and rescans the max.
// Reset: synchronous; no clearing pass, the table is gated by the point count.
// Input and engine stall on their own through a two-beat command queue.
module timed_delay_profile_interpolator
  import tdpi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  tdpi_in_if.sink     in_ch,
  tdpi_out_if.source  out_ch,
  tdpi_cfg_if.sink    cfg_ch
);
  logic loop_mode_r;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) loop_mode_r <= 1'b0;
    else if (cfg_ch.valid) loop_mode_r <= cfg_ch.data;
  end

  tdpi_front u_front (.clk, .rst_n, .in_ch, .cmd_valid, .cmd, .cmd_take);

  tdpi_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk, .rst_n, .loop_mode(loop_mode_r), .cmd_valid, .cmd, .cmd_take, .out_ch);
endmodule
